@@ sv/mpd_pkg.sv @@
`default_nettype none

package mpd_pkg;

    localparam int unsigned POS_WIDTH_DEF = 16;
    localparam int unsigned NUM_BTN       = 3;
    localparam int unsigned OUT_POS_W     = 16;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_HELD    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BTN_LEFT   = 2'd0,
        BTN_RIGHT  = 2'd1,
        BTN_MIDDLE = 2'd2
    } btn_t;

    // one possible event per button, built when the packet is taken
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [2:0] held;
    } slot_t;

endpackage

`default_nettype wire

@@ sv/mpd_btn_events.sv @@
`default_nettype none

module mpd_btn_events (
    input  wire logic                                 [2:0] prev_btn,
    input  wire logic                                 [2:0] now_btn,
    output      mpd_pkg::slot_t [mpd_pkg::NUM_BTN-1:0]      slots
);

    always_comb begin
        logic [2:0] run_held;
        run_held = prev_btn;
        for (int i = 0; i < mpd_pkg::NUM_BTN; i++) begin
            // buttons not yet examined keep their old state in the mask
            run_held[i]    = now_btn[i];
            slots[i].held  = run_held;
            slots[i].valid = prev_btn[i] | now_btn[i];
            unique case ({prev_btn[i], now_btn[i]})
                2'b01:   slots[i].kind = mpd_pkg::KIND_PRESS;
                2'b10:   slots[i].kind = mpd_pkg::KIND_RELEASE;
                2'b11:   slots[i].kind = mpd_pkg::KIND_HELD;
                default: slots[i].kind = mpd_pkg::KIND_HELD;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/mouse_packet_event_decoder_top.sv @@
`default_nettype none

// Mouse packet decoder. Each request on the s_ side is one three-byte packet;
// its X delta is added to, and its Y delta subtracted from, a saturating
// pointer position of POS_WIDTH bits, and for left, right and middle in that
// order each button that was or is down yields one event on the m_ side
// (0 to 3 events, tlast on the final one). A packet is decoded in the cycle
// it is taken and its events are held in a three-slot event register that
// drives the output port directly; events leave one per cycle while m_tready
// is high, and the next packet is taken in the same cycle as the last event
// of the previous one, or whenever no events are pending.
module mouse_packet_event_decoder_top #(
    parameter int unsigned POS_WIDTH = mpd_pkg::POS_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // status_byte, dx_byte, dy_byte
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,   // button_id, pointer_x, pointer_y, held_mask, zero pad
    output      logic [1:0]  m_tuser,   // event_kind
    output      logic        m_tlast
);

    localparam int unsigned NB = mpd_pkg::NUM_BTN;
    localparam int unsigned OW = mpd_pkg::OUT_POS_W;

    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic        [NB-1:0]        prev_reg;
    logic        [NB-1:0]        pend_reg, pend_next;
    mpd_pkg::slot_t [NB-1:0]     slot_reg;
    mpd_pkg::slot_t [NB-1:0]     slots;
    logic signed [OW-1:0]        out_x_reg, out_y_reg;

    logic                        s_take, m_take;
    logic        [NB-1:0]        now_btn, new_pend, sel, rest;
    logic signed [POS_WIDTH:0]   sum_x, sum_y;
    logic signed [POS_WIDTH:0]   dx_ext, dy_ext;
    mpd_pkg::slot_t              cur;
    mpd_pkg::btn_t               cur_btn;

    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    assign now_btn = s_tdata[NB-1:0];

    mpd_btn_events u_btn (
        .prev_btn (prev_reg),
        .now_btn  (now_btn),
        .slots    (slots)
    );

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            new_pend[i] = slots[i].valid;
        end
    end

    // saturating position update, one guard bit
    always_comb begin
        dx_ext = (POS_WIDTH+1)'($signed(s_tdata[15:8]));
        dy_ext = (POS_WIDTH+1)'($signed(s_tdata[23:16]));
        sum_x  = {pos_x_reg[POS_WIDTH-1], pos_x_reg} + dx_ext;
        sum_y  = {pos_y_reg[POS_WIDTH-1], pos_y_reg} - dy_ext;
        if (sum_x[POS_WIDTH] != sum_x[POS_WIDTH-1]) begin
            pos_x_next = sum_x[POS_WIDTH] ? POS_MIN : POS_MAX;
        end else begin
            pos_x_next = sum_x[POS_WIDTH-1:0];
        end
        if (sum_y[POS_WIDTH] != sum_y[POS_WIDTH-1]) begin
            pos_y_next = sum_y[POS_WIDTH] ? POS_MIN : POS_MAX;
        end else begin
            pos_y_next = sum_y[POS_WIDTH-1:0];
        end
    end

    // lowest pending slot goes out first
    always_comb begin
        priority if (pend_reg[0]) begin
            sel     = 3'b001;
            cur     = slot_reg[0];
            cur_btn = mpd_pkg::BTN_LEFT;
        end else if (pend_reg[1]) begin
            sel     = 3'b010;
            cur     = slot_reg[1];
            cur_btn = mpd_pkg::BTN_RIGHT;
        end else begin
            sel     = pend_reg & 3'b100;
            cur     = slot_reg[2];
            cur_btn = mpd_pkg::BTN_MIDDLE;
        end
    end

    assign rest     = pend_reg & ~sel;
    assign m_tvalid = |pend_reg;
    assign m_tlast  = ~|rest;
    assign m_take   = m_tvalid & m_tready;
    assign s_tready = ~m_tvalid | (m_take & m_tlast);
    assign s_take   = s_tvalid & s_tready;

    assign m_tuser = cur.kind;
    assign m_tdata = {3'b000, cur.held, out_y_reg, out_x_reg, cur_btn};

    always_comb begin
        pend_next = pend_reg;
        if (m_take) begin
            pend_next = rest;
        end
        if (s_take) begin
            pend_next = new_pend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            prev_reg  <= '0;
            pend_reg  <= '0;
        end else begin
            pend_reg <= pend_next;
            if (s_take) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                prev_reg  <= now_btn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            slot_reg  <= slots;
            out_x_reg <= OW'(pos_x_next);
            out_y_reg <= OW'(pos_y_next);
        end
    end

endmodule

`default_nettype wire

@@ sv/mpd_checker.sv @@
`default_nettype none

module mpd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled event must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");

    // events of one packet follow back to back with the same position
    a_same_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata[33:2]))
        else $error("packet events split or position changed");

    // press shows the button held, release shows it up
    a_press_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mpd_pkg::KIND_PRESS |->
            ((m_tdata[36:34] >> m_tdata[1:0]) & 3'b001) == 3'b001)
        else $error("press without held bit");

    a_release_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mpd_pkg::KIND_RELEASE |->
            ((m_tdata[36:34] >> m_tdata[1:0]) & 3'b001) == 3'b000)
        else $error("release with held bit");

    // input only stalls behind pending events
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing pending");

endmodule

bind mouse_packet_event_decoder_top mpd_checker u_mpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/sv/mouse_packet_event_checker.sv @@
`timescale 1ns / 1ps

module mouse_packet_event_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // status_byte, dx_byte, dy_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // button_id, pointer_x, pointer_y, held_mask, zero pad
    input  logic [1:0]  m_tuser,   // event_kind
    input  logic        m_tlast,
    output int          errors,
    output int          outstanding
);

    localparam int POS_MAX = (1 << (mpd_pkg::POS_WIDTH_DEF - 1)) - 1;
    localparam int POS_MIN = -POS_MAX - 1;

    typedef struct {
        mpd_pkg::kind_t kind;
        mpd_pkg::btn_t  button;
        logic [15:0]    x;
        logic [15:0]    y;
        logic [2:0]     held;
        logic           last;
    } button_ev_t;

    button_ev_t  events_due[$];
    int          cur_x;
    int          cur_y;
    logic [2:0]  buttons_prev;

    function automatic int clamp_pos(int v);
        if (v > POS_MAX) begin
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            return POS_MIN;
        end
        return v;
    endfunction

    // position update first, then one event per button that was or is down
    function automatic void decode_packet(logic [23:0] pkt);
        logic [2:0] now_btn;
        logic [2:0] held;
        logic       was;
        logic       is_down;
        button_ev_t ev;
        int         first;
        now_btn = pkt[2:0];
        held    = buttons_prev;
        first   = events_due.size();
        cur_x   = clamp_pos(cur_x + int'($signed(pkt[15:8])));
        cur_y   = clamp_pos(cur_y - int'($signed(pkt[23:16])));
        for (int b = 0; b < mpd_pkg::NUM_BTN; b++) begin
            was     = buttons_prev[b];
            is_down = now_btn[b];
            if (!was && !is_down) begin
                continue;
            end
            if (!was) begin
                ev.kind = mpd_pkg::KIND_PRESS;
                held[b] = 1'b1;
            end else if (!is_down) begin
                ev.kind = mpd_pkg::KIND_RELEASE;
                held[b] = 1'b0;
            end else begin
                ev.kind = mpd_pkg::KIND_HELD;
            end
            ev.button = mpd_pkg::btn_t'(b);
            ev.x      = cur_x[15:0];
            ev.y      = cur_y[15:0];
            ev.held   = held;
            ev.last   = 1'b0;
            events_due.push_back(ev);
        end
        if (events_due.size() > first) begin
            events_due[events_due.size() - 1].last = 1'b1;
        end
        buttons_prev = now_btn;
    endfunction

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        errors = errors + 1;
    endtask

    task automatic check_event();
        button_ev_t ev;
        if (events_due.size() == 0) begin
            report("unexpected event", m_tdata, '0);
            return;
        end
        ev = events_due.pop_front();
        if (m_tuser != ev.kind)         report("event_kind", m_tuser, ev.kind);
        if (m_tdata[1:0] != ev.button)  report("button_id", m_tdata[1:0], ev.button);
        if (m_tdata[17:2] != ev.x)      report("pointer_x", m_tdata[17:2], ev.x);
        if (m_tdata[33:18] != ev.y)     report("pointer_y", m_tdata[33:18], ev.y);
        if (m_tdata[36:34] != ev.held)  report("held_mask", m_tdata[36:34], ev.held);
        if (m_tdata[39:37] != 3'b000)   report("tdata pad", m_tdata[39:37], 3'b000);
        if (m_tlast != ev.last)         report("last_event", m_tlast, ev.last);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            events_due.delete();
            cur_x        = 0;
            cur_y        = 0;
            buttons_prev = '0;
            errors       = 0;
            outstanding <= 0;
        end else begin
            // results leaving at this edge belong to older requests
            if (m_tvalid && m_tready) begin
                check_event();
            end
            if (s_tvalid && s_tready) begin
                decode_packet(s_tdata);
            end
            outstanding <= events_due.size();
        end
    end

endmodule

@@ tb/sv/mouse_packet_event_decoder_top_tb.sv @@
`timescale 1ns / 1ps

module mouse_packet_event_decoder_top_tb;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        calm     = 1'b0;
    int          errors;
    int          outstanding;

    always #6 aclk = ~aclk;

    mouse_packet_event_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mouse_packet_event_checker u_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 31);
    end

    task automatic send_packet(logic [7:0] status, logic [7:0] dx, logic [7:0] dy);
        if (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dy, dx, status};
        do @(posedge aclk); while (!s_tready);
    endtask

    // outstanding is registered, hence the first step before polling
    task automatic drain_events();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_packet(8'h00, 8'h00, 8'h00);   // nothing down, no event
        send_packet(8'h01, 8'h01, 8'hFF);
        send_packet(8'h07, 8'h7F, 8'h80);   // largest dx, smallest dy
        send_packet(8'h07, 8'h80, 8'h7F);   // all held, smallest dx, largest dy
        send_packet(8'h05, 8'h00, 8'h00);
        send_packet(8'h00, 8'hFF, 8'h01);
        send_packet(8'hF8, 8'h55, 8'hAA);   // upper status bits only
        send_packet(8'hFA, 8'hAA, 8'h55);
        send_packet(8'h04, 8'h00, 8'h00);
        send_packet(8'h03, 8'h10, 8'hF0);
        send_packet(8'h06, 8'hF0, 8'h10);
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'h02, 8'h01, 8'h01);
        send_packet(8'h02, 8'h00, 8'h00);
        send_packet(8'h00, 8'h00, 8'h00);
        drain_events();

        // long drift pushes X into its upper clamp and Y into its lower one
        for (int i = 0; i < 470; i++) begin
            calm = (i >= 300 && i < 380);
            if (i == 200) begin
                drain_events();
            end
            if (i < 280) begin
                send_packet(8'($urandom), 8'($urandom_range(110, 127)),
                            8'($urandom_range(110, 127)));
            end else begin
                send_packet(8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        calm = 1'b0;

        drain_events();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("mouse_packet_event_decoder_top test passed");
        end else begin
            $display("mouse_packet_event_decoder_top test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("mouse_packet_event_decoder_top test failed");
        $finish;
    end

endmodule
